// ----- rtl/wsd_pkg.sv -----
// Package for the WebSocket frame deframer.
// Holds the length width, opcode and kind codes, the parse phase type and the result struct.
// Depends on nothing; the parser, the output register and the top import it.
package wsd_pkg;

	localparam int LENGTH_WIDTH = 64;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [7:0] OPCODE_MASK = 8'h0F;
	localparam logic [7:0] MASK_BIT    = 8'h80;
	localparam logic [7:0] LEN7_MASK   = 8'h7F;
	localparam logic [6:0] LEN7_EXT16  = 7'd126;
	localparam logic [6:0] LEN7_EXT64  = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef logic [LENGTH_WIDTH-1:0] len_t;

	typedef enum logic [1:0] {
		KIND_TEXT  = 2'd0,
		KIND_PING  = 2'd1,
		KIND_CLOSE = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXT     = 6'b000100,
		PH_MASK    = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CLOSED  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		kind_t      frame_kind;
		logic       byte_present;
		logic       last_in_frame;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} result_beat_t;

	function automatic kind_t kind_of(input logic [3:0] opcode);
		kind_t k;
		case (opcode)
			OP_TEXT:  k = KIND_TEXT;
			OP_PING:  k = KIND_PING;
			OP_CLOSE: k = KIND_CLOSE;
			default:  k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/wsd_in_if.sv -----
// Byte stream channel into the deframer: valid, ready and one data byte per beat.
// Depends on nothing.
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ----- rtl/wsd_out_if.sv -----
// Result channel out of the deframer: valid, ready and one unmasked payload result per beat.
// Depends on nothing.
interface wsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [1:0] frame_kind;
	logic       byte_present;
	logic       last_in_frame;

	modport source (output valid, output payload_byte, output frame_kind,
		output byte_present, output last_in_frame, input ready);
	modport sink (input valid, input payload_byte, input frame_kind,
		input byte_present, input last_in_frame, output ready);
endinterface

// ----- rtl/wsd_parser.sv -----
// Frame parser: header, extended length and mask key decode, payload unmasking.
// Updates its state on each accepted byte and produces at most one result beat.
// Depends on wsd_pkg.
module wsd_parser
	import wsd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   data_byte,
	output result_beat_t beat
);

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	len_t        len_q, len_d;
	logic        ovf_q, ovf_d;
	logic [3:0]  left_q, left_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  idx_q, idx_d;

	logic [6:0]  len7;
	len_t        len_shift;
	len_t        len_new;
	logic        ovf_new;
	logic        go_payload;
	logic [7:0]  key_byte;
	kind_t       kind;
	phase_t      end_phase;

	assign len7      = 7'(data_byte & LEN7_MASK);
	assign len_shift = {len_q[LENGTH_WIDTH-9:0], data_byte};
	assign ovf_new   = ovf_q | (len_q[LENGTH_WIDTH-1:LENGTH_WIDTH-8] != '0);
	assign key_byte  = key_q[{~idx_q, 3'b000} +: 8];
	assign kind      = kind_of(opcode_q);
	assign end_phase = (opcode_q == OP_CLOSE) ? PH_CLOSED : PH_HDR0;

	always_comb begin
		phase_d    = phase_q;
		opcode_d   = opcode_q;
		mask_d     = mask_q;
		len_d      = len_q;
		ovf_d      = ovf_q;
		left_d     = left_q;
		key_d      = key_q;
		idx_d      = idx_q;
		len_new    = len_q;
		go_payload = 1'b0;
		beat       = '0;
		beat.res.frame_kind = kind;

		case (phase_q)
			PH_HDR0: begin
				opcode_d = 4'(data_byte & OPCODE_MASK);
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				mask_d = (data_byte & MASK_BIT) != 8'h00;
				idx_d  = '0;
				key_d  = '0;
				ovf_d  = 1'b0;
				len_d  = '0;
				if (len7 == LEN7_EXT16) begin
					left_d  = EXT16_BYTES;
					phase_d = PH_EXT;
				end else if (len7 == LEN7_EXT64) begin
					left_d  = EXT64_BYTES;
					phase_d = PH_EXT;
				end else begin
					len_new = LENGTH_WIDTH'(len7);
					len_d   = len_new;
					if (mask_d) begin
						left_d  = KEY_BYTES;
						phase_d = PH_MASK;
					end else begin
						go_payload = 1'b1;
					end
				end
			end
			PH_EXT: begin
				len_d  = len_shift;
				ovf_d  = ovf_new;
				left_d = left_q - 4'd1;
				if (left_q == 4'd1) begin
					len_new = ovf_new ? '1 : len_shift;
					len_d   = len_new;
					if (mask_q) begin
						left_d  = KEY_BYTES;
						phase_d = PH_MASK;
					end else begin
						go_payload = 1'b1;
					end
				end
			end
			PH_MASK: begin
				key_d  = {key_q[23:0], data_byte};
				left_d = left_q - 4'd1;
				if (left_q == 4'd1) begin
					go_payload = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				idx_d = idx_q + 2'd1;
				len_d = (len_q == '0) ? '0 : len_q - len_t'(1);
				beat.valid             = 1'b1;
				beat.res.payload_byte  = data_byte ^ (mask_q ? key_byte : 8'h00);
				beat.res.byte_present  = 1'b1;
				beat.res.last_in_frame = (len_q <= len_t'(1));
				if (len_q <= len_t'(1)) begin
					phase_d = end_phase;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		if (go_payload) begin
			if (len_new == '0) begin
				beat.valid             = 1'b1;
				beat.res.last_in_frame = 1'b1;
				phase_d                = end_phase;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		if (!take) begin
			beat.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			left_q   <= '0;
			key_q    <= '0;
			idx_q    <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			len_q    <= len_d;
			ovf_q    <= ovf_d;
			left_q   <= left_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
		end
	end

endmodule

// ----- rtl/wsd_out_reg.sv -----
// Output register with a one-entry skid stage for the result channel.
// Decouples the parser's input ready from the downstream ready.
// Depends on wsd_pkg and wsd_out_if.
module wsd_out_reg
	import wsd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  result_beat_t  beat,
	output logic          room,
	wsd_out_if.source     tx
);

	result_t out_q, skid_q;
	logic    out_v_q, skid_v_q;
	logic    pop;

	assign pop  = out_v_q && tx.ready;
	assign room = !skid_v_q;

	assign tx.valid         = out_v_q;
	assign tx.payload_byte  = out_q.payload_byte;
	assign tx.frame_kind    = out_q.frame_kind;
	assign tx.byte_present  = out_q.byte_present;
	assign tx.last_in_frame = out_q.last_in_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (beat.valid) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (beat.valid) begin
			if (!out_v_q || pop) begin
				out_q <= beat.res;
			end else begin
				skid_q <= beat.res;
			end
		end
	end

endmodule

// ----- rtl/websocket_frame_deframer_top.sv -----
// Top level of the WebSocket frame deframer: parser plus skid-buffered output register.
// Depends on wsd_pkg, wsd_in_if, wsd_out_if, wsd_parser and wsd_out_reg.
//
//   channel  dir  beat payload
//   rx       in   data_byte[7:0]
//   tx       out  payload_byte[7:0], frame_kind[1:0], byte_present, last_in_frame
//
// One byte per cycle while the skid stage is empty; each result is registered in the output register or skid stage.
// The parse state updates on each accepted byte; the single-entry skid stage sets
// how far a stalled tx lets rx run ahead (one extra result).
// arst_n clears the parser to await the first header byte and empties the output.
// After a close frame ends, bytes are taken and dropped until reset.
module websocket_frame_deframer_top
	import wsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	wsd_in_if.sink    rx,
	wsd_out_if.source tx
);

	result_beat_t beat;
	logic         room;
	logic         take;

	assign rx.ready = room;
	assign take     = rx.valid && room;

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (rx.data_byte),
		.beat      (beat)
	);

	wsd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat),
		.room   (room),
		.tx     (tx)
	);

endmodule
